// ===== src/ntq_pkg.sv =====
// ntq_pkg: shared types, sizes and codes for the note-off timing queue.
// Used by ntq_front, ntq_back and note_off_timed_queue_unit.
package ntq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SCAN_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_OFFS    = 32;
  localparam int CNT_W       = $clog2(MAX_OFFS + 1);
  localparam int ENTRY_W     = 43;

  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_ADVANCE = 3'd1;
  localparam logic [2:0] CMD_NOTE_ON = 3'd2;
  localparam logic [2:0] CMD_OTHER   = 3'd3;
  localparam logic [2:0] CMD_END     = 3'd4;

  localparam logic [1:0] KIND_OFF   = 2'd0;
  localparam logic [1:0] KIND_ON    = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] time_step;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [31:0] duration;
  } request_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] delta;
    logic [3:0]  out_channel;
    logic [6:0]  out_note;
    logic [6:0]  out_velocity;
    logic        last;
  } result_t;

  // classified request: arg is time_step for advance, duration otherwise
  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] arg;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [6:0]  velocity;
  } op_t;

  typedef struct packed {
    logic [31:0] off_time;
    logic [3:0]  channel;
    logic [6:0]  note;
  } slot_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_link_t;

endpackage

// ===== src/ntq_ram.sv =====
// ntq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ntq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ntq_front.sv =====
// ntq_front: accepts requests, drops unknown commands, queues ops (two deep).
// Depends on ntq_pkg.
module ntq_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ntq_pkg::request_t request,
  output logic              busy,
  output ntq_pkg::op_link_t link,
  input  logic              op_pop
);
  import ntq_pkg::*;

  op_t        q0;
  op_t        q1;
  logic [1:0] fill;
  logic [1:0] fill_next;
  logic       push;
  op_t        op_new;

  always_comb begin
    busy            = (fill == 2'd2);
    push            = start && !busy && (request.command <= CMD_END);
    op_new.cmd      = request.command;
    op_new.arg      = (request.command == CMD_ADVANCE) ? request.time_step : request.duration;
    op_new.channel  = request.channel;
    op_new.note     = request.note;
    op_new.velocity = request.velocity;
    link.valid      = (fill != 2'd0);
    link.op         = q0;
    case ({push, op_pop})
      2'b10:   fill_next = fill + 2'd1;
      2'b01:   fill_next = fill - 2'd1;
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      q0 <= (fill == 2'd2) ? q1 : op_new;
    end else if (push) begin
      if (fill == 2'd0) begin
        q0 <= op_new;
      end else begin
        q1 <= op_new;
      end
    end
  end

endmodule

// ===== src/ntq_back.sv =====
// ntq_back: executes ops against the pending note-off table (one slot per cycle
// scans), emits note-offs and final results. Depends on ntq_pkg, ntq_ram.
module ntq_back (
  input  logic              clk,
  input  logic              rst,
  input  ntq_pkg::op_link_t link,
  output logic              op_pop,
  output logic              valid,
  output ntq_pkg::result_t  result
);
  import ntq_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]             state;
  op_t                    cur;
  logic [QUEUE_DEPTH-1:0] slot_valid;
  logic [31:0]            now_time;
  logic [31:0]            written_time;
  logic [SCAN_W-1:0]      scan_idx;
  logic                   rd_pend;
  logic [SLOT_W-1:0]      rd_idx;
  logic [ENTRY_W-1:0]     rd_data;
  slot_t                  rd_slot;
  logic                   rd_live;
  logic [CNT_W-1:0]       count;

  logic                   best_found;
  logic [SLOT_W-1:0]      best_idx;
  slot_t                  best_slot;
  logic                   match_found;
  logic [SLOT_W-1:0]      match_idx;
  logic                   free_found;
  logic [SLOT_W-1:0]      free_idx;

  logic                   issue;
  logic                   scan_last;
  logic                   take_off;
  logic                   do_queue;
  slot_t                  wr_slot;
  logic [SLOT_W-1:0]      wr_addr;

  always_comb begin
    op_pop    = (state == S_IDLE) && link.valid;
    issue     = (state == S_SCAN) && (scan_idx < SCAN_W'(QUEUE_DEPTH));
    rd_slot   = slot_t'(rd_data);
    rd_live   = slot_valid[rd_idx];
    scan_last = rd_pend && (rd_idx == SLOT_W'(QUEUE_DEPTH - 1));
    take_off  = best_found && (cur.cmd == CMD_END || best_slot.off_time <= now_time)
                && (count != CNT_W'(MAX_OFFS));
    do_queue  = (state == S_DECIDE) && !take_off && (cur.cmd == CMD_NOTE_ON)
                && (cur.velocity != 7'd0) && (match_found || free_found);
    wr_addr          = match_found ? match_idx : free_idx;
    wr_slot.off_time = now_time + cur.arg;
    wr_slot.channel  = cur.channel;
    wr_slot.note     = cur.note;
  end

  ntq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (do_queue),
    .waddr (wr_addr),
    .wdata (wr_slot),
    .raddr (scan_idx[SLOT_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slot_valid   <= '0;
      now_time     <= 32'd0;
      written_time <= 32'd0;
      scan_idx     <= '0;
      rd_pend      <= 1'b0;
      count        <= '0;
      best_found   <= 1'b0;
      match_found  <= 1'b0;
      free_found   <= 1'b0;
      valid        <= 1'b0;
    end else begin
      valid   <= 1'b0;
      rd_pend <= issue;
      rd_idx  <= scan_idx[SLOT_W-1:0];
      if (issue) begin
        scan_idx <= scan_idx + SCAN_W'(1);
      end
      if (rd_pend) begin
        if (rd_live) begin
          if (!best_found || rd_slot.off_time < best_slot.off_time) begin
            best_found <= 1'b1;
            best_idx   <= rd_idx;
            best_slot  <= rd_slot;
          end
          if (!match_found && rd_slot.channel == cur.channel && rd_slot.note == cur.note) begin
            match_found <= 1'b1;
            match_idx   <= rd_idx;
          end
        end else begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (link.valid) begin
            cur <= link.op;
            unique case (link.op.cmd)
              CMD_START: begin
                slot_valid   <= '0;
                now_time     <= 32'd0;
                written_time <= 32'd0;
              end
              CMD_ADVANCE: begin
                now_time <= now_time + link.op.arg;
              end
              default: begin
                state       <= S_SCAN;
                count       <= '0;
                scan_idx    <= '0;
                best_found  <= 1'b0;
                match_found <= 1'b0;
                free_found  <= 1'b0;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_last) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          valid <= 1'b1;
          if (take_off) begin
            result.kind         <= KIND_OFF;
            result.delta        <= best_slot.off_time - written_time;
            result.out_channel  <= best_slot.channel;
            result.out_note     <= best_slot.note;
            result.out_velocity <= 7'd0;
            result.last         <= 1'b0;
            written_time        <= best_slot.off_time;
            slot_valid[best_idx] <= 1'b0;
            count       <= count + CNT_W'(1);
            state       <= S_SCAN;
            scan_idx    <= '0;
            best_found  <= 1'b0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
          end else begin
            result.last  <= 1'b1;
            state        <= S_IDLE;
            case (cur.cmd)
              CMD_NOTE_ON: begin
                result.kind         <= KIND_ON;
                result.delta        <= now_time - written_time;
                result.out_channel  <= cur.channel;
                result.out_note     <= cur.note;
                result.out_velocity <= cur.velocity;
                written_time        <= now_time;
              end
              CMD_OTHER: begin
                result.kind         <= KIND_OTHER;
                result.delta        <= now_time - written_time;
                result.out_channel  <= 4'd0;
                result.out_note     <= 7'd0;
                result.out_velocity <= 7'd0;
                written_time        <= now_time;
              end
              default: begin
                result.kind         <= KIND_END;
                result.delta        <= 32'd0;
                result.out_channel  <= 4'd0;
                result.out_note     <= 7'd0;
                result.out_velocity <= 7'd0;
              end
            endcase
            if (do_queue && !match_found) begin
              slot_valid[free_idx] <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/note_off_timed_queue_unit.sv =====
// note_off_timed_queue_unit: top level of the note-off timing queue.
// Depends on ntq_pkg, ntq_front, ntq_back (and ntq_ram below it).
//
// Usage:
//   Requests: drive request and raise start; the request is taken on a rising
//   edge with start high and busy low. A two-entry queue sits behind the port,
//   so up to two requests are taken while the executor is working.
//   Results: each result is on result for one cycle with valid high; the
//   receiver must take it then. result.last marks the final result of a request.
// Operation (k = note-offs emitted by the request):
//   start track and advance time: taken in the idle state, no result.
//   note on, other event, end of track: (k + 1) table scans, one result at the
//   end of every scan; the slot table is scanned one slot per cycle through
//   its RAM read port.
//   Unknown command codes are dropped at the port and cost nothing.
// Reset: synchronous rst empties the request queue, marks every slot free and
//   zeroes current and written time; no clearing pass is needed.
module note_off_timed_queue_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ntq_pkg::request_t request,
  output logic              busy,
  output logic              valid,
  output ntq_pkg::result_t  result
);
  import ntq_pkg::*;

  op_link_t link;
  logic     op_pop;

  ntq_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .link    (link),
    .op_pop  (op_pop)
  );

  ntq_back u_back (
    .clk    (clk),
    .rst    (rst),
    .link   (link),
    .op_pop (op_pop),
    .valid  (valid),
    .result (result)
  );

`ifndef NO_ASSERTIONS
  a_mid_is_off : assert property (@(posedge clk) disable iff (rst)
    valid && !result.last |-> result.kind == KIND_OFF)
    else $error("non-final result is not a note off");

  a_final_last : assert property (@(posedge clk) disable iff (rst)
    valid && result.kind != KIND_OFF |-> result.last)
    else $error("final result without last");

  a_end_delta : assert property (@(posedge clk) disable iff (rst)
    valid && result.kind == KIND_END |-> result.delta == 32'd0)
    else $error("end marker with nonzero delta");

  a_busy_rise : assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");
`endif

endmodule
